### design/assert_macros.svh
// Assertion macros for the RTL files; decimal_integer_parser includes them.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the usual clk_i and rst_ni.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_STD(lbl, prop, msg)

`endif

`endif

### design/dip_pkg.sv
`default_nettype none

package dip_pkg;

  // Largest supported accumulator width.
  localparam int DipMaxWidth = 64;

  // Fixed field widths of the streams.
  localparam int CharW   = 8;
  localparam int ValueW  = 64;
  localparam int StatusW = 3;

  // Configuration port.
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 2;
  localparam logic [CfgAddrW-1:0] CfgWidthSel   = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgSignedMode = 1'b1;
  localparam logic [1:0] WidthSelReset = 2'd3;

  // Character codes.
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] DigitMax  = 8'd9;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StOk    = 3'd0,
    StEmpty = 3'd1,
    StSign  = 3'd2,
    StBad   = 3'd3,
    StRange = 3'd4
  } status_e;

  // Per-string control state.
  typedef struct packed {
    status_e err;
    logic    at_start;
    logic    negative;
  } dip_flags_t;

  // One result transaction.
  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           status;
  } dip_result_t;

endpackage

`default_nettype wire

### design/dip_step.sv
`default_nettype none

module dip_step import dip_pkg::*; #(
  parameter int MAX_WIDTH = DipMaxWidth
) (
  input  wire logic [CharW-1:0]     char_i,
  input  wire logic                 last_i,
  input  wire logic [1:0]           width_sel_i,
  input  wire logic                 signed_mode_i,
  input  wire logic [MAX_WIDTH-1:0] acc_i,
  input  wire dip_flags_t           flags_i,
  output logic [MAX_WIDTH-1:0]      acc_o,
  output dip_flags_t                flags_o,
  output dip_result_t               result_o
);

  localparam int SumW = MAX_WIDTH + 4;
  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

  logic [6:0]           w_raw;
  logic [6:0]           w_eff;
  logic [6:0]           ones_n;
  logic [MAX_WIDTH-1:0] ones;
  logic [MAX_WIDTH-1:0] lim;
  logic [CharW-1:0]     digit;
  logic [SumW-1:0]      acc_ext;
  logic [SumW-1:0]      prod_sum;
  logic                 handled;
  status_e              err_next;
  logic                 neg_next;
  logic [MAX_WIDTH-1:0] acc_next;
  logic [ValueW-1:0]    acc_wide;

  // Magnitude limit for the selected width and sign.
  always_comb begin
    w_raw  = 7'd8 << width_sel_i;
    w_eff  = (w_raw > MaxW) ? MaxW : w_raw;
    ones_n = signed_mode_i ? (w_eff - 7'd1) : w_eff;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      ones[i] = (7'(i) < ones_n);
    end
    lim = ones + MAX_WIDTH'(signed_mode_i && flags_i.negative);
  end

  // Times ten as a shift-add, plus the digit, with headroom for the range check.
  assign digit    = char_i - CharZero;
  assign acc_ext  = SumW'(acc_i);
  assign prod_sum = (acc_ext << 3) + (acc_ext << 1) + SumW'(digit);

  // Character handling; the first error sticks until the end of the string.
  always_comb begin
    acc_next = acc_i;
    err_next = flags_i.err;
    neg_next = flags_i.negative;
    handled  = 1'b0;
    if (flags_i.err == StOk) begin
      if (flags_i.at_start) begin
        if (char_i == CharNul) begin
          err_next = StEmpty;
          handled  = 1'b1;
        end else if (signed_mode_i && (char_i == CharPlus || char_i == CharMinus)) begin
          if (last_i) begin
            err_next = StSign;
          end else begin
            neg_next = (char_i == CharMinus);
          end
          handled = 1'b1;
        end
      end
      if (!handled) begin
        if (digit > DigitMax) begin
          err_next = StBad;
        end else if (prod_sum > SumW'(lim)) begin
          err_next = StRange;
        end else begin
          acc_next = prod_sum[MAX_WIDTH-1:0];
        end
      end
    end
  end

  // Result of a string that ends with this character.
  assign acc_wide = ValueW'(acc_next);

  always_comb begin
    if (err_next != StOk) begin
      result_o.value  = '0;
      result_o.status = err_next;
    end else begin
      result_o.value  = (signed_mode_i && neg_next) ? (ValueW'(0) - acc_wide) : acc_wide;
      result_o.status = StOk;
    end
  end

  // Next state; the last character rearms for a new string.
  always_comb begin
    if (last_i) begin
      acc_o            = '0;
      flags_o.err      = StOk;
      flags_o.at_start = 1'b1;
      flags_o.negative = 1'b0;
    end else begin
      acc_o            = acc_next;
      flags_o.err      = err_next;
      flags_o.at_start = 1'b0;
      flags_o.negative = neg_next;
    end
  end

endmodule

`default_nettype wire

### design/dip_out_buf.sv
`default_nettype none

module dip_out_buf import dip_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire dip_result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output dip_result_t      result_o
);

  logic        valid_q;
  logic        valid_d;
  dip_result_t result_q;

  // The slot is free when empty or when its transaction completes now.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

### design/decimal_integer_parser.sv
// Decimal string to integer converter.
// Characters arrive on the s_axis stream, one byte per transaction, with
// s_axis_tlast on the final byte of a string. Each string yields one result
// transaction on m_axis: tdata carries the value (zero- or sign-extended to
// 64 bits, zero on error) and tuser the status code.
// Width and signedness come from the cfg_* write port; the user must write it
// only while no string is in flight, which the block itself does not enforce.
// Throughput is one character per cycle unless a final character waits for a
// busy result slot: the times-ten update and the range compare against the
// width limit form one combinational path around the accumulator register.
// A character is first captured in the input register and processed from there;
// the result of a final byte goes to the output register that drives m_axis.
// Reset selects 64-bit unsigned mode and clears all string state.
// When the receiver stalls, the result stays in the output register; further
// non-final characters keep flowing, while a final character waits in the
// input register and s_axis_tready drops until the result slot frees up.
`default_nettype none
`include "assert_macros.svh"

module decimal_integer_parser import dip_pkg::*; #(
  parameter int MAX_WIDTH = DipMaxWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Character stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [CharW-1:0]    s_axis_tdata,   // [7:0] char_code
  input  wire logic                s_axis_tlast,
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [ValueW-1:0]        m_axis_tdata,   // [63:0] value
  output logic [StatusW-1:0]       m_axis_tuser    // [2:0] status
);

  logic [1:0]           width_sel_q;
  logic                 signed_mode_q;
  logic                 in_valid_q;
  logic [CharW-1:0]     in_char_q;
  logic                 in_last_q;
  logic [MAX_WIDTH-1:0] acc_q;
  logic [MAX_WIDTH-1:0] acc_d;
  dip_flags_t           flags_q;
  dip_flags_t           flags_d;
  dip_result_t          step_res;
  dip_result_t          out_res;
  logic                 out_free;
  logic                 step_fire;
  logic                 in_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_sel_q   <= WidthSelReset;
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgWidthSel:   width_sel_q   <= cfg_wdata_i[1:0];
        CfgSignedMode: signed_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A character is processed unless it ends a string and the result slot is busy.
  assign step_fire     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || step_fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Per-character update.
  dip_step #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_step (
    .char_i       (in_char_q),
    .last_i       (in_last_q),
    .width_sel_i  (width_sel_q),
    .signed_mode_i(signed_mode_q),
    .acc_i        (acc_q),
    .flags_i      (flags_q),
    .acc_o        (acc_d),
    .flags_o      (flags_d),
    .result_o     (step_res)
  );

  // String state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q            <= '0;
      flags_q.err      <= StOk;
      flags_q.at_start <= 1'b1;
      flags_q.negative <= 1'b0;
    end else if (step_fire) begin
      acc_q   <= acc_d;
      flags_q <= flags_d;
    end
  end

  // Result register.
  dip_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step_fire && in_last_q),
    .result_i(step_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .result_o(out_res)
  );

  assign m_axis_tdata = out_res.value;
  assign m_axis_tuser = out_res.status;

  // Checks.
  `ASSERT_STD(a_res_from_last, $rose(m_axis_tvalid) |-> $past(step_fire && in_last_q), "result without a final character")
  `ASSERT_STD(a_rearm_after_last, step_fire && in_last_q |=> flags_q.at_start && flags_q.err == StOk && acc_q == '0, "state not cleared after a string")
  `ASSERT_STD(a_error_value_zero, m_axis_tvalid && m_axis_tuser != StOk |-> m_axis_tdata == '0, "nonzero value with an error status")
  `ASSERT_STD(a_error_latched, flags_q.err != StOk && !(step_fire && in_last_q) |=> flags_q.err == $past(flags_q.err), "latched error changed inside a string")

endmodule

`default_nettype wire

### verif/decimal_integer_parser_tb.sv
`timescale 1ns / 100ps

module decimal_integer_parser_tb;
  import dip_pkg::*;

  typedef logic [CharW-1:0] char_t;

  localparam int ItemsPerSlot  = 15;
  localparam int DrainCycles   = 6;
  localparam int HoldOffCycles = 300;

  // Clock, reset and block ports.
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i   = CfgWidthSel;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  char_t              s_axis_tdata  = CharNul;  // [7:0] char_code
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ValueW-1:0]  m_axis_tdata;             // [63:0] value
  logic [StatusW-1:0] m_axis_tuser;             // [2:0] status

  // Traffic shaping for the sender and the receiver.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_cycles    = 0;

  // Run statistics.
  int chars_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;

  // Parser state as the testbench expects it to be.
  logic [1:0]  model_width_sel = WidthSelReset;
  logic        model_signed    = 1'b0;
  logic [63:0] acc_mag         = '0;
  status_e     acc_err         = StOk;
  logic        acc_at_start    = 1'b1;
  logic        acc_negative    = 1'b0;
  dip_result_t parsed_results[$];

  decimal_integer_parser dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Largest magnitude that fits the current width and sign mode.
  function automatic logic [63:0] magnitude_limit(logic neg);
    int unsigned w;
    logic [63:0] half;
    w = 8 << model_width_sel;
    if (w > DipMaxWidth) w = DipMaxWidth;
    half = 64'd1 << (w - 1);
    if (model_signed) return neg ? half : half - 64'd1;
    return (w >= 64) ? '1 : (64'd1 << w) - 64'd1;
  endfunction

  // Advances the expected parser state by one accepted character and queues
  // the expected result when the character closes a string.
  function automatic void parse_step(char_t ch, logic last);
    logic [63:0] lim;
    char_t       d;
    logic        handled;
    dip_result_t res;
    handled = 1'b0;
    if (acc_err == StOk) begin
      if (acc_at_start) begin
        if (ch == CharNul) begin
          acc_err = StEmpty;
          handled = 1'b1;
        end else if (model_signed && (ch == CharPlus || ch == CharMinus)) begin
          if (last) acc_err = StSign;
          else acc_negative = (ch == CharMinus);
          handled = 1'b1;
        end
      end
      if (!handled) begin
        d = ch - CharZero;
        if (d > DigitMax) begin
          acc_err = StBad;
        end else begin
          // Both the times-ten step and the digit step must stay in range.
          lim = magnitude_limit(acc_negative);
          if (acc_mag > lim / 10) begin
            acc_err = StRange;
          end else begin
            acc_mag = acc_mag * 10;
            if (acc_mag > lim - d) acc_err = StRange;
            else acc_mag = acc_mag + d;
          end
        end
      end
    end
    acc_at_start = 1'b0;
    if (last) begin
      res.status = acc_err;
      if (acc_err != StOk) res.value = '0;
      else res.value = (model_signed && acc_negative) ? -acc_mag : acc_mag;
      parsed_results.push_back(res);
      acc_mag      = '0;
      acc_err      = StOk;
      acc_at_start = 1'b1;
      acc_negative = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Offers one character, with random gaps before it, and waits until the
  // transaction completes.
  task automatic send_char(char_t ch, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
    parse_step(ch, last);
  endtask

  task automatic send_string(char_t s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  // Drops the stream and waits until every result has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (parsed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes both registers once the block has gone idle.
  task automatic write_cfg(logic [1:0] width_sel, logic signed_mode);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgWidthSel;
    cfg_wdata_i <= width_sel;
    model_width_sel = width_sel;
    @(negedge clk_i);
    cfg_addr_i  <= CfgSignedMode;
    cfg_wdata_i <= {1'b0, signed_mode};
    model_signed = signed_mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Appends the decimal digits of a magnitude.
  function automatic void append_decimal(ref char_t s[$], input logic [63:0] mag);
    char_t digits[$];
    do begin
      digits.push_front(CharZero + char_t'(mag % 64'd10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digits[i]) s.push_back(digits[i]);
  endfunction

  // Builds one random string; most are numbers aimed at the range limits of
  // the current setting, the rest are empty strings, lone signs and noise.
  function automatic void make_string(ref char_t s[$]);
    logic        neg;
    logic [63:0] lim;
    int          kind;
    s.delete();
    kind = $urandom_range(99);
    neg  = model_signed && $urandom_range(1);
    lim  = magnitude_limit(neg);
    if (kind < 5) begin
      s.push_back(CharNul);
      repeat ($urandom_range(2)) s.push_back(char_t'($urandom_range(255)));
    end else if (kind < 10) begin
      s.push_back($urandom_range(1) ? CharPlus : CharMinus);
    end else if (kind < 20) begin
      repeat ($urandom_range(1, 4)) s.push_back(char_t'($urandom_range(255)));
    end else begin
      // An explicit plus is a bad character in unsigned mode.
      if (neg) s.push_back(CharMinus);
      else if ($urandom_range(9) == 0) s.push_back(CharPlus);
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) s.push_back(CharZero);
      case ($urandom_range(3))
        0: append_decimal(s, lim - $urandom_range(5));
        1: begin
          // Overflows on the final add.
          append_decimal(s, lim / 10);
          s.push_back(CharZero + char_t'($urandom_range(32'(lim % 10) + 1, 9)));
        end
        2: begin
          // Overflows on the final multiply.
          append_decimal(s, lim / 10 + $urandom_range(1, 3));
          s.push_back(CharZero + char_t'($urandom_range(9)));
        end
        default: append_decimal(s, {$urandom, $urandom} >> $urandom_range(63));
      endcase
      // Corrupt one byte of a well-formed number now and then.
      if (kind >= 90) s[$urandom_range(s.size() - 1)] = char_t'($urandom_range(255));
    end
  endfunction

  // Checks each result transaction against the oldest expected one.
  always @(posedge clk_i) begin
    dip_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (parsed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h status %0d",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = parsed_results.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch($sformatf("value %h, expected %h", m_axis_tdata, want.value));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
      end
    end
  end

  // Result receiver: random stalls, or a long hold-off when one is pending.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Limits, sign handling and each error kind at 8 bits, after one string in the reset setting.
  task automatic test_directed_cases();
    send_text("0");
    write_cfg(2'd0, 1'b0);
    send_text("255");
    send_text("256");
    send_text("260");
    send_text("+");
    send_char(CharNul, 1'b1);
    send_char(CharZero + 8'd7, 1'b0);
    send_char(CharNul, 1'b1);
    send_text("/");
    send_text(":");
    write_cfg(2'd0, 1'b1);
    send_text("-128");
    send_text("128");
    send_text("-");
    send_text("+9");
  endtask

  // Random strings under every width and sign mode with the given traffic.
  task automatic test_random_strings(int unsigned send_pct, int unsigned recv_pct);
    int    first;
    int    sel;
    int    budget;
    char_t s[$];
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    first = $urandom_range(7);
    for (int k = 0; k < 8; k++) begin
      sel = (first + k) % 8;
      write_cfg(sel[1:0], sel[2]);
      budget = chars_sent + ItemsPerSlot;
      while (chars_sent < budget) begin
        make_string(s);
        send_string(s);
      end
    end
  endtask

  // The receiver holds off while short strings keep coming, so the output
  // slot fills up and the input side has to stall.
  task automatic test_backpressure();
    char_t s[$];
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_cfg(2'd0, 1'b0);
    @(posedge clk_i);
    hold_cycles = HoldOffCycles;
    repeat (20) begin
      s.delete();
      repeat ($urandom_range(1, 3)) s.push_back(CharZero + char_t'($urandom_range(9)));
      send_string(s);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_strings(0, 0);
    test_random_strings(85, 0);
    test_random_strings(0, 85);
    test_random_strings(33, 33);
    test_backpressure();
    wait_drained();

    $display("Sent %0d characters and checked %0d results over all widths and sign modes,",
             chars_sent, results_seen);
    $display("with sender gaps, receiver stalls and a %0d-cycle output hold-off.",
             HoldOffCycles);
    if (mismatches == 0 && parsed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
